// ===== hw/rtl/tket_pkg.sv =====
// Package: types, codes and calendar checks of the appointment table.
`default_nettype none
package tket_pkg;

   localparam int TKET_DEPTH = 64;
   localparam logic [6:0] MAX_ENTRIES_RESET = 7'd64;

   localparam logic [2:0] CMD_INSERT    = 3'd0;
   localparam logic [2:0] CMD_COUNT     = 3'd1;
   localparam logic [2:0] CMD_EARLIEST  = 3'd2;
   localparam logic [2:0] CMD_DEL_EARLY = 3'd3;
   localparam logic [2:0] CMD_DEL_PAT   = 3'd4;

   localparam logic [2:0] STAT_OK    = 3'd0;
   localparam logic [2:0] STAT_DATE  = 3'd1;
   localparam logic [2:0] STAT_TIME  = 3'd2;
   localparam logic [2:0] STAT_FULL  = 3'd3;
   localparam logic [2:0] STAT_EMPTY = 3'd4;

   localparam logic [13:0] YEAR_MAX   = 14'd9999;
   localparam logic [4:0]  HOUR_MAX   = 5'd23;
   localparam logic [5:0]  MINUTE_MAX = 6'd59;
   localparam logic [14:0] RECIP25    = 15'd20972;

   localparam logic [4:0] MONTH_DAYS [16] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0};

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] patient_id;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [4:0]  hour;
      logic [5:0]  minute;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  match_count;
      logic [6:0]  entry_count;
      logic [15:0] found_patient;
      logic [4:0]  found_day;
      logic [3:0]  found_month;
      logic [13:0] found_year;
      logic [4:0]  found_hour;
      logic [5:0]  found_minute;
   } rsp_type;

   typedef struct packed {
      logic [15:0] patient;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [4:0]  hour;
      logic [5:0]  minute;
   } entry_type;

   typedef enum logic [1:0] {
      ROUTE_DONE,
      ROUTE_SCAN,
      ROUTE_PACK
   } route_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_PACK_RD,
      ST_PACK_EV,
      ST_DONE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic latch;
      logic scan_eval;
      logic pack_start;
      logic pack_eval;
      logic finish;
   } ctl_type;

   typedef struct packed {
      route_type route;
      logic      at_end;
      logic      pack_next;
   } sts_type;

   function automatic logic date_ok(logic [4:0] d, logic [3:0] m, logic [13:0] y);
      logic [28:0] prod;
      logic        div25;
      logic        leap;
      logic [4:0]  lim;
      prod  = 29'(y) * 29'(RECIP25);
      div25 = prod[18:0] < 19'(RECIP25);
      leap  = (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
      lim   = (m == 4'd2 && leap) ? 5'd29 : MONTH_DAYS[m];
      return (y != 14'd0) && (y <= YEAR_MAX) && (d != 5'd0) && (d <= lim);
   endfunction

   function automatic logic [33:0] order_key(entry_type e);
      return {e.year, e.month, e.day, e.hour, e.minute};
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/timestamp_keyed_entry_table.sv =====
// Top level: fixed-capacity appointment table with valid/ready channels.
//
// Usage: present a command on req_* (valid/ready); one response per
// command returns on rsp_* (valid/ready). csr_wr_en writes max_entries,
// the capacity in use; it is to be written only while the block is idle,
// which the block itself does not enforce. Reset sets it to 64.
// Commands are taken one at a time: req_ready is high only in idle.
// Insert, an unknown command and a rejected command need no pass over the
// table; count on date and earliest take one scan pass, delete patient one
// compaction pass, and delete earliest two passes, a scan pass and then a
// compaction pass. Every pass reads the entry store through its one
// registered read port, with a read state and an evaluate state per entry.
// Reset empties the table at once (count cleared) and returns to idle.
// A stalled receiver holds the response; the next command waits for it.
`default_nettype none
module timestamp_keyed_entry_table import tket_pkg::*; #(
   parameter int DEPTH = TKET_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   input  wire logic       csr_wr_en,
   input  wire logic [6:0] csr_wr_data
);
   ctl_type ctl;
   sts_type sts;

   tket_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   tket_datapath #(.DEPTH(DEPTH)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ctl         (ctl),
      .sts         (sts)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("command taken while response pending");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STAT_EMPTY) |-> (rsp_data.entry_count == 7'd0))
      else $error("empty status with stored entries");

   a_reject_no_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STAT_OK) |-> (rsp_data.match_count == 7'd0))
      else $error("match count on rejected command");

   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("response too early");
endmodule
`default_nettype wire

// ===== hw/rtl/tket_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tket_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/tket_ctrl.sv =====
// Controller: sequences insert, scan and compaction passes over the table.
`default_nettype none
module tket_ctrl import tket_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output ctl_type      ctl
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.latch = 1'b1;
               unique case (sts.route)
                  ROUTE_SCAN: state_in = ST_SCAN_RD;
                  ROUTE_PACK: state_in = ST_PACK_RD;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN_RD: begin
            if (sts.at_end) begin
               if (sts.pack_next) begin
                  ctl.pack_start = 1'b1;
                  state_in = ST_PACK_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               state_in = ST_SCAN_EV;
            end
         end
         ST_SCAN_EV: begin
            ctl.scan_eval = 1'b1;
            state_in = ST_SCAN_RD;
         end
         ST_PACK_RD: begin
            state_in = sts.at_end ? ST_DONE : ST_PACK_EV;
         end
         ST_PACK_EV: begin
            ctl.pack_eval = 1'b1;
            state_in = ST_PACK_RD;
         end
         ST_DONE: begin
            ctl.finish = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== hw/rtl/tket_datapath.sv =====
// Datapath: entry store, scan indexes, counters and response register.
`default_nettype none
module tket_datapath import tket_pkg::*; #(
   parameter int DEPTH = TKET_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    req_data,
   output rsp_type         rsp_data,
   input  wire logic       csr_wr_en,
   input  wire logic [6:0] csr_wr_data,
   input  wire ctl_type    ctl,
   output sts_type         sts
);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EW = (CW > 7) ? CW : 7;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic [6:0]    max_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] r_ff, r_in;
   logic [CW-1:0] w_ff, w_in;
   logic [CW-1:0] best_ff, best_in;
   logic [CW-1:0] k_ff, k_in;
   logic [2:0]    status_ff, status_in;
   req_type       req_ff, req_in;
   entry_type     best_ent_ff, best_ent_in;
   rsp_type       rsp_ff, rsp_in;

   entry_type     rd_ent, new_ent, wr_ent;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          full, date_good, time_good, skip;

   tket_ram #(.WIDTH($bits(entry_type)), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_addr (r_ff[AW-1:0]),
      .rd_data (rd_ent)
   );

   assign new_ent = '{patient: req_data.patient_id, day: req_data.day,
                      month: req_data.month, year: req_data.year,
                      hour: req_data.hour, minute: req_data.minute};
   assign full      = (EW'(count_ff) >= EW'(max_ff)) || (count_ff == DEPTH_C);
   assign date_good = date_ok(req_data.day, req_data.month, req_data.year);
   assign time_good = (req_data.hour <= HOUR_MAX) && (req_data.minute <= MINUTE_MAX);
   assign skip = ((req_ff.command == CMD_DEL_PAT) && (rd_ent.patient == req_ff.patient_id))
              || ((req_ff.command == CMD_DEL_EARLY) && (r_ff == best_ff));

   always_comb begin
      sts.at_end    = (r_ff == count_ff);
      sts.pack_next = (req_ff.command == CMD_DEL_EARLY);
      case (req_data.command) inside
         CMD_COUNT:                  sts.route = date_good ? ROUTE_SCAN : ROUTE_DONE;
         CMD_EARLIEST, CMD_DEL_EARLY: sts.route = (count_ff != '0) ? ROUTE_SCAN : ROUTE_DONE;
         CMD_DEL_PAT:                sts.route = ROUTE_PACK;
         default:                    sts.route = ROUTE_DONE;
      endcase
   end

   always_comb begin
      count_in    = count_ff;
      r_in        = r_ff;
      w_in        = w_ff;
      best_in     = best_ff;
      k_in        = k_ff;
      status_in   = status_ff;
      req_in      = req_ff;
      best_ent_in = best_ent_ff;
      rsp_in      = rsp_ff;
      wr_en       = 1'b0;
      wr_addr     = w_ff[AW-1:0];
      wr_ent      = rd_ent;
      if (ctl.latch) begin
         req_in    = req_data;
         r_in      = '0;
         w_in      = '0;
         k_in      = '0;
         status_in = STAT_OK;
         case (req_data.command) inside
            CMD_INSERT: begin
               if (full) begin
                  status_in = STAT_FULL;
               end else if (!date_good) begin
                  status_in = STAT_DATE;
               end else if (!time_good) begin
                  status_in = STAT_TIME;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  wr_ent   = new_ent;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_COUNT: if (!date_good) status_in = STAT_DATE;
            CMD_EARLIEST, CMD_DEL_EARLY: if (count_ff == '0) status_in = STAT_EMPTY;
            default: status_in = STAT_OK;
         endcase
      end
      if (ctl.scan_eval) begin
         r_in = r_ff + 1'b1;
         if (req_ff.command == CMD_COUNT) begin
            if (rd_ent.day == req_ff.day && rd_ent.month == req_ff.month
                && rd_ent.year == req_ff.year) begin
               k_in = k_ff + 1'b1;
            end
         end else if (r_ff == '0 || order_key(rd_ent) < order_key(best_ent_ff)) begin
            best_in     = r_ff;
            best_ent_in = rd_ent;
         end
      end
      if (ctl.pack_start) begin
         r_in = '0;
         w_in = '0;
      end
      if (ctl.pack_eval) begin
         r_in = r_ff + 1'b1;
         if (skip) begin
            if (req_ff.command == CMD_DEL_PAT) k_in = k_ff + 1'b1;
         end else begin
            wr_en = 1'b1;
            w_in  = w_ff + 1'b1;
         end
      end
      if (ctl.finish) begin
         if (req_ff.command == CMD_DEL_EARLY || req_ff.command == CMD_DEL_PAT) begin
            count_in = w_ff;
         end
         rsp_in             = '0;
         rsp_in.status      = status_ff;
         rsp_in.entry_count = 7'(count_in);
         if (req_ff.command == CMD_COUNT || req_ff.command == CMD_DEL_PAT) begin
            rsp_in.match_count = 7'(k_ff);
         end
         if ((req_ff.command == CMD_EARLIEST || req_ff.command == CMD_DEL_EARLY)
             && status_ff == STAT_OK) begin
            rsp_in.found_patient = best_ent_ff.patient;
            rsp_in.found_day     = best_ent_ff.day;
            rsp_in.found_month   = best_ent_ff.month;
            rsp_in.found_year    = best_ent_ff.year;
            rsp_in.found_hour    = best_ent_ff.hour;
            rsp_in.found_minute  = best_ent_ff.minute;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= MAX_ENTRIES_RESET;
         count_ff <= '0;
      end else begin
         if (csr_wr_en) max_ff <= csr_wr_data;
         count_ff <= count_in;
      end
      r_ff        <= r_in;
      w_ff        <= w_in;
      best_ff     <= best_in;
      k_ff        <= k_in;
      status_ff   <= status_in;
      req_ff      <= req_in;
      best_ent_ff <= best_ent_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire
